// ===== sv/sitdc_pkg.sv =====
`default_nettype none
package sitdc_pkg;

  // display geometry
  localparam int MAX_DIGITS = 16;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 5;
  localparam int CODE_W     = 4;

  // character codes
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd10;
  localparam logic [CODE_W-1:0] CODE_MINUS = 4'd11;

  // register reset value
  localparam logic [CNT_W-1:0] DIGITS_RESET = 5'd8;

  // reciprocal of ten, scaled by 2^35
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;
    logic div_done;
    logic emit_last;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/signed_int_to_digit_codes.sv =====
`default_nettype none
// Formats a signed 32-bit value into digits_in_use display positions (clamped to
// 16; zero gives no results) and sends one character per position, leftmost
// first, each on the out_ ports for exactly one cycle with out_valid high. The
// receiver cannot stall, so it must take every transfer as it appears. An item
// computes d decimal digits (1 to 10, at most n, the position count) one at a
// time on the shared multiply-by-reciprocal divide-by-ten unit, in a multiply
// then a divide state each, then sends the n positions via the output register.
// start is taken while busy is low and the digit count is nonzero; the next
// item can be taken in the cycle the last result is shown. The user must write
// the register through cfg_ only while the block is idle; it is not enforced.
module signed_int_to_digit_codes (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [31:0]                   in_value,
  input  wire logic [sitdc_pkg::POS_W-1:0]   in_point_position,
  input  wire logic                          in_zero_fill,
  output logic                               out_valid,
  output logic [sitdc_pkg::POS_W-1:0]        out_position,
  output logic [sitdc_pkg::CODE_W-1:0]       out_char_code,
  output logic                               out_dot_on,
  output logic                               out_last_digit,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sitdc_pkg::CNT_W-1:0]   cfg_data
);
  import sitdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  sitdc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // conversion and output datapath
  sitdc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_value          (in_value),
    .in_point_position (in_point_position),
    .in_zero_fill      (in_zero_fill),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_position      (out_position),
    .out_char_code     (out_char_code),
    .out_dot_on        (out_dot_on),
    .out_last_digit    (out_last_digit)
  );

endmodule
`default_nettype wire

// ===== sv/sitdc_ctrl.sv =====
`default_nettype none
module sitdc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sitdc_pkg::status_t status,
  output sitdc_pkg::cmd_t        cmd
);
  import sitdc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && !status.n_zero) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = status.div_done ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (status.emit_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && !status.n_zero;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/sitdc_dp.sv =====
`default_nettype none
module sitdc_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sitdc_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic [31:0]                    in_value,
  input  wire logic [sitdc_pkg::POS_W-1:0]    in_point_position,
  input  wire logic                           in_zero_fill,
  input  wire sitdc_pkg::cmd_t                cmd,
  output sitdc_pkg::status_t                  status,
  output logic                                out_valid,
  output logic [sitdc_pkg::POS_W-1:0]         out_position,
  output logic [sitdc_pkg::CODE_W-1:0]        out_char_code,
  output logic                                out_dot_on,
  output logic                                out_last_digit
);
  import sitdc_pkg::*;

  logic [CNT_W-1:0]  digits_r;
  logic [CNT_W-1:0]  n_clamp;
  logic [31:0]       mag_r;
  logic [63:0]       prod_r;
  logic              neg_r;
  logic              fill_r;
  logic [POS_W-1:0]  point_r;
  logic [CNT_W-1:0]  n_r;
  logic [POS_W-1:0]  nm1_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [POS_W-1:0]  k_r;
  logic [CODE_W-1:0] dig_r [MAX_DIGITS];

  logic [31:0]       quot;
  logic [31:0]       rem_full;
  logic [POS_W-1:0]  pos_cur;
  logic [CODE_W-1:0] code_cur;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_dot_r;
  logic              out_last_r;

  // digit count register, clamped to the display size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= DIGITS_RESET;
    end else if (cfg_we) begin
      digits_r <= cfg_data;
    end
  end

  assign n_clamp = (digits_r > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digits_r;

  // divide by ten: quotient from the registered product, remainder by shift-add
  assign quot      = {3'b000, prod_r[63:RECIP_SHIFT]};
  assign rem_full  = mag_r - ((quot << 3) + (quot << 1));
  assign count_nxt = count_r + CNT_W'(1);

  assign status.n_zero    = (n_clamp == '0);
  assign status.div_done  = (quot == '0) || (count_nxt == n_r);
  assign status.emit_last = (k_r == '0);

  // conversion datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r   <= in_value[31];
      mag_r   <= in_value[31] ? (32'd0 - in_value) : in_value;
      fill_r  <= in_zero_fill;
      point_r <= in_point_position;
      n_r     <= n_clamp;
      nm1_r   <= POS_W'(n_clamp - CNT_W'(1));
      k_r     <= POS_W'(n_clamp - CNT_W'(1));
      count_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= mag_r * RECIP_TEN;
    end
    if (cmd.div) begin
      dig_r[count_r[POS_W-1:0]] <= rem_full[CODE_W-1:0];
      mag_r   <= quot;
      count_r <= count_nxt;
    end
    if (cmd.emit) begin
      k_r <= k_r - POS_W'(1);
    end
  end

  // character for the position being sent; k counts from the right
  assign pos_cur = nm1_r - k_r;

  always_comb begin
    if (CNT_W'(k_r) < count_r) begin
      code_cur = dig_r[k_r];
    end else if ((CNT_W'(k_r) == count_r) && neg_r) begin
      code_cur = CODE_MINUS;
    end else if (fill_r) begin
      code_cur = '0;
    end else begin
      code_cur = CODE_BLANK;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pos_r  <= pos_cur;
      out_code_r <= code_cur;
      out_dot_r  <= (point_r != '0) && (point_r <= nm1_r) && (point_r == pos_cur);
      out_last_r <= (k_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_pos_r;
  assign out_char_code  = out_code_r;
  assign out_dot_on     = out_dot_r;
  assign out_last_digit = out_last_r;

endmodule
`default_nettype wire
